### hw/rtl/ers_pkg.sv
// Shared types and constants for the escaped ray selector.
`timescale 1ns / 1ps
package ers_pkg;
  localparam int DIR_FRAC_BITS_DEF = 14;
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int NORM_TOP          = 29;
  localparam int QUEUE_DEPTH       = 2;

  typedef enum logic [1:0] {
    STATUS_SELECTED   = 2'd0,
    STATUS_SKIPPED    = 2'd1,
    STATUS_UNFINISHED = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        surface;
    logic [31:0]        next_photon;
    logic               final_item;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } out_item_t;

  // Work handed from the front to the direction unit.
  typedef struct packed {
    status_t     status;
    logic        calc;
    logic [31:0] org_x;
    logic [31:0] org_y;
    logic [31:0] org_z;
    logic [31:0] ext_x;
    logic [31:0] ext_y;
    logic [31:0] ext_z;
  } job_t;
endpackage

### hw/rtl/ers_front.sv
// Front end: tracks the current ray and classifies each ray end.
`timescale 1ns / 1ps
module ers_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  ers_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             in_full,
  output logic             job_push,
  output ers_pkg::job_t    job
);
  logic [31:0] prev_x_r, prev_y_r, prev_z_r;
  logic        prev_surf_r, prev_surf_nxt;
  logic        open_r, open_nxt;
  logic        acc, ends;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;
  assign ends    = (in_data.next_photon == 32'd0);

  always_comb begin
    open_nxt      = open_r;
    prev_surf_nxt = prev_surf_r;
    job_push      = 1'b0;
    job.status    = ers_pkg::STATUS_SKIPPED;
    job.calc      = 1'b0;
    job.org_x     = prev_x_r;
    job.org_y     = prev_y_r;
    job.org_z     = prev_z_r;
    job.ext_x     = in_data.pos_x;
    job.ext_y     = in_data.pos_y;
    job.ext_z     = in_data.pos_z;
    if (acc) begin
      if (!ends) begin
        prev_surf_nxt = (in_data.surface != 16'd0);
        open_nxt      = !in_data.final_item;
        job_push      = in_data.final_item;
        job.status    = ers_pkg::STATUS_UNFINISHED;
      end else begin
        job_push = 1'b1;
        job.calc = open_r && (in_data.surface == 16'd0) && prev_surf_r;
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      prev_surf_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
    end else begin
      open_r      <= open_nxt;
      prev_surf_r <= prev_surf_nxt;
      if (acc && !ends) begin
        prev_x_r <= in_data.pos_x;
        prev_y_r <= in_data.pos_y;
        prev_z_r <= in_data.pos_z;
      end
    end
  end
endmodule

### hw/rtl/ers_queue.sv
// Short job queue between the front end and the direction unit.
`timescale 1ns / 1ps
module ers_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ers_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          vld,
  output ers_pkg::job_t rdata
);
  localparam int PW = $clog2(ers_pkg::QUEUE_DEPTH);
  localparam int CNTW = $clog2(ers_pkg::QUEUE_DEPTH + 1);

  ers_pkg::job_t mem_r [ers_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CNTW-1:0] cnt_r;
  logic            do_wr, do_rd;

  assign full  = (cnt_r == CNTW'(ers_pkg::QUEUE_DEPTH));
  assign vld   = (cnt_r != '0);
  assign rdata = mem_r[rp_r];
  assign do_wr = push && !full;
  assign do_rd = pop && vld;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == PW'(ers_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == PW'(ers_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CNTW'(do_wr) - CNTW'(do_rd);
    end
  end
endmodule

### hw/rtl/ers_dir.sv
// Back end: normalizes the exit vector and holds the result register.
`timescale 1ns / 1ps
module ers_dir #(
  parameter int DIR_FRAC_BITS = ers_pkg::DIR_FRAC_BITS_DEF,
  parameter int COORD_WIDTH   = ers_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_vld,
  input  ers_pkg::job_t      job,
  output logic               job_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output ers_pkg::out_item_t out_data
);
  localparam int DW   = COORD_WIDTH + 1;
  localparam int MW   = (DW > ers_pkg::NORM_TOP + 1) ? DW : ers_pkg::NORM_TOP + 1;
  localparam int SW   = ers_pkg::NORM_TOP + 1;
  localparam int NUMW = SW + DIR_FRAC_BITS + 1;
  localparam int QB   = DIR_FRAC_BITS + 2;
  localparam int DCW  = $clog2(QB + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIFF = 8'b0000_0010,
    S_NORM = 8'b0000_0100,
    S_SQ   = 8'b0000_1000,
    S_SQRT = 8'b0001_0000,
    S_PREP = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t             st_r, st_nxt;
  ers_pkg::job_t      job_r;
  logic [MW-1:0]      mag_r [3];
  logic               neg_r [3];
  logic [1:0]         cnt_r;
  logic [61:0]        acc_r;
  logic [62:0]        n_r, root_r, bit_r;
  logic [30:0]        rem_r [3];
  logic [QB-1:0]      low_r [3];
  logic [QB-1:0]      q_r   [3];
  logic [DCW-1:0]     dcnt_r;
  ers_pkg::out_item_t out_r, out_nxt;
  logic               out_vld_r, out_wr, out_free;
  logic [MW-1:0]      or_all;
  logic [59:0]        prod;
  logic [SW-1:0]      sq_in;
  logic [62:0]        trial;
  logic [30:0]        norm;
  logic signed [DW-1:0] diff [3];
  logic [31:0]        org [3];
  logic [31:0]        ext [3];
  logic signed [15:0] dir [3];

  function automatic logic signed [DW-1:0] sx(input logic [31:0] v);
    logic [COORD_WIDTH+31:0] z;
    logic [COORD_WIDTH-1:0]  c;
    z = {{COORD_WIDTH{1'b0}}, v};
    c = z[COORD_WIDTH-1:0];
    return {c[COORD_WIDTH-1], c};
  endfunction

  assign out_empty = !out_vld_r;
  assign out_data  = out_r;
  assign out_free  = !out_vld_r || out_pop;
  assign or_all    = mag_r[0] | mag_r[1] | mag_r[2];
  assign sq_in     = mag_r[cnt_r][SW-1:0];
  assign prod      = sq_in * sq_in;
  assign trial     = root_r + bit_r;
  assign norm      = root_r[30:0];
  assign org[0] = job_r.org_x;  assign ext[0] = job_r.ext_x;
  assign org[1] = job_r.org_y;  assign ext[1] = job_r.ext_y;
  assign org[2] = job_r.org_z;  assign ext[2] = job_r.ext_z;

  always_comb begin
    logic [QB+15:0] qx;
    for (int i = 0; i < 3; i++) begin
      diff[i] = sx(ext[i]) - sx(org[i]);
      qx      = {16'd0, q_r[i]};
      if (neg_r[i]) qx = ~qx + 1'b1;
      dir[i]  = qx[15:0];
    end
  end

  always_comb begin
    st_nxt  = st_r;
    job_pop = 1'b0;
    out_wr  = 1'b0;
    out_nxt = '0;
    out_nxt.status = ers_pkg::STATUS_SKIPPED;
    unique case (st_r)
      S_IDLE: begin
        if (job_vld) begin
          if (job.calc) begin
            job_pop = 1'b1;
            st_nxt  = S_DIFF;
          end else if (out_free) begin
            job_pop = 1'b1;
            out_wr  = 1'b1;
            out_nxt.status = job.status;
          end
        end
      end
      S_DIFF: st_nxt = S_NORM;
      S_NORM: begin
        if (or_all == '0) begin
          // zero length: skip the ray
          if (out_free) begin
            out_wr = 1'b1;
            st_nxt = S_IDLE;
          end
        end else if ((or_all >> SW) == '0 && or_all[SW-1]) begin
          st_nxt = S_SQ;
        end
      end
      S_SQ:   if (cnt_r == 2'd2) st_nxt = S_SQRT;
      S_SQRT: if (bit_r[0]) st_nxt = S_PREP;
      S_PREP: st_nxt = S_DIV;
      S_DIV:  if (dcnt_r == DCW'(QB - 1)) st_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          out_wr = 1'b1;
          out_nxt.status   = ers_pkg::STATUS_SELECTED;
          out_nxt.origin_x = job_r.org_x;
          out_nxt.origin_y = job_r.org_y;
          out_nxt.origin_z = job_r.org_z;
          out_nxt.dir_x    = dir[0];
          out_nxt.dir_y    = dir[1];
          out_nxt.dir_z    = dir[2];
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      out_vld_r <= out_wr || (out_vld_r && !out_pop);
    end
  end

  always_ff @(posedge clk) begin
    logic [NUMW-1:0] num;
    logic [31:0]     t;
    if (out_wr) out_r <= out_nxt;
    if (job_pop) job_r <= job;
    unique case (st_r)
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= diff[i][DW-1];
          mag_r[i] <= MW'(diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]));
        end
      end
      S_NORM: begin
        // walk the leading one of the largest magnitude onto the top bit
        for (int i = 0; i < 3; i++) begin
          if ((or_all >> SW) != '0) mag_r[i] <= mag_r[i] >> 1;
          else if (!or_all[SW-1])   mag_r[i] <= mag_r[i] << 1;
        end
        cnt_r <= 2'd0;
        acc_r <= '0;
      end
      S_SQ: begin
        acc_r <= acc_r + 62'(prod);
        cnt_r <= cnt_r + 1'b1;
        n_r    <= 63'(acc_r + 62'(prod));
        root_r <= '0;
        bit_r  <= 63'd1 << 62;
      end
      S_SQRT: begin
        if (n_r >= trial) begin
          n_r    <= n_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_PREP: begin
        for (int i = 0; i < 3; i++) begin
          num = {1'b0, mag_r[i][SW-1:0], {DIR_FRAC_BITS{1'b0}}} + NUMW'(norm >> 1);
          rem_r[i] <= 31'(num[NUMW-1:QB]);
          low_r[i] <= num[QB-1:0];
          q_r[i]   <= '0;
        end
        dcnt_r <= '0;
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          t = {rem_r[i], low_r[i][QB-1]};
          if (t >= {1'b0, norm}) begin
            rem_r[i] <= 31'(t - {1'b0, norm});
            q_r[i]   <= {q_r[i][QB-2:0], 1'b1};
          end else begin
            rem_r[i] <= t[30:0];
            q_r[i]   <= {q_r[i][QB-2:0], 1'b0};
          end
          low_r[i] <= low_r[i] << 1;
        end
        dcnt_r <= dcnt_r + 1'b1;
      end
      default: ;
    endcase
  end
endmodule

### hw/rtl/escaped_ray_selector.sv
// Top level of the escaped ray selector.
//   channel | ports                      | transaction when
//   input   | in_push, in_full, in_data  | in_push && !in_full
//   result  | out_pop, out_empty, out_data | out_pop && !out_empty
// The front enqueues a job at a ray end and at a final item that ends no ray.
// A skipped or unfinished job is written from idle straight into the result
// register; a selected ray passes the difference, the one-bit normalize walk,
// the 32-step square root and the DIR_FRAC_BITS+2 step divide.
// Reset (rst_n low, synchronous) drops any held photon and pending jobs.
// Input stalls only when the two-entry job queue is full.
`timescale 1ns / 1ps
module escaped_ray_selector #(
  parameter int DIR_FRAC_BITS = ers_pkg::DIR_FRAC_BITS_DEF,
  parameter int COORD_WIDTH   = ers_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ers_pkg::in_item_t  in_data,
  input  logic               out_pop,
  output logic               out_empty,
  output ers_pkg::out_item_t out_data
);
  logic          q_full, job_push, job_vld, job_pop;
  ers_pkg::job_t job_in, job_out;

  ers_front u_front (
    .clk, .rst_n, .in_push, .in_data, .q_full, .in_full,
    .job_push, .job(job_in)
  );

  ers_queue u_queue (
    .clk, .rst_n, .push(job_push), .wdata(job_in), .full(q_full),
    .pop(job_pop), .vld(job_vld), .rdata(job_out)
  );

  ers_dir #(
    .DIR_FRAC_BITS(DIR_FRAC_BITS),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dir (
    .clk, .rst_n, .job_vld, .job(job_out), .job_pop,
    .out_pop, .out_empty, .out_data
  );
endmodule
